[rtl/wir_pkg.sv]
// Shared types and constants for the weighted isotonic regression block.
// Used by every module of the block; depends on nothing.
package wir_pkg;

	// Capacity of the item stores and derived widths.
	localparam int MAX_ITEMS = 1024;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;

	// Number of bit steps of the serial multiply and divide.
	localparam int ITERS = 32;

	// Command codes of an input item.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Status codes reported with a read result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_W   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	// Request to the shared arithmetic unit.
	typedef struct packed {
		logic               start;
		arith_op_t          op;
		logic signed [63:0] a;
		logic [47:0]        w;
	} arith_req_t;

	// Answer of the shared arithmetic unit.
	typedef struct packed {
		logic               done;
		logic signed [63:0] result;
	} arith_rsp_t;

	// One entry of the pool stack.
	typedef struct packed {
		logic signed [31:0] mean;
		logic [47:0]        wsum;
		logic signed [63:0] sum;
		logic [IDX_W-1:0]   last_idx;
	} pool_ent_t;

	// Commands from the front end to the fit core.
	typedef struct packed {
		logic               load;
		logic [IDX_W-1:0]   load_addr;
		logic signed [31:0] value;
		logic [31:0]        weight;
		logic               fit_start;
		logic [CNT_W-1:0]   fit_n;
		logic               rd;
		logic [IDX_W-1:0]   rd_idx;
	} core_cmd_t;

	// Events and read data from the fit core.
	typedef struct packed {
		logic               zero_w;
		logic               fit_done;
		logic signed [31:0] rd_data;
	} core_rsp_t;

endpackage

[rtl/wir_arith.sv]
// Shared serial arithmetic unit: weighted item term (shift-add multiply)
// and saturating Q16.16 pool mean (restoring divide). Depends on wir_pkg.
module wir_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  wir_pkg::arith_req_t req,
	output wir_pkg::arith_rsp_t rsp
);

	localparam int CW = $clog2(wir_pkg::ITERS);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DCHK,
		A_DIV,
		A_FIN
	} a_state_t;

	a_state_t           state_q;
	wir_pkg::arith_op_t op_q;
	logic               neg_q;
	logic               ovf_q;
	logic [CW-1:0]      cnt_q;
	logic [63:0]        mag_q;
	logic [63:0]        acc_q;
	logic [31:0]        mplr_q;
	logic [47:0]        w_q;
	logic [47:0]        rem_q;
	logic [31:0]        low_q;
	logic [31:0]        quo_q;
	logic               done_q;
	logic signed [63:0] result_q;

	logic [48:0]        trial;
	logic               trial_ge;
	logic [48:0]        trial_diff;
	logic [47:0]        prod_sh;
	logic [32:0]        qmag;
	logic [32:0]        qlim;
	logic [31:0]        mean_res;
	logic signed [63:0] fin_res;

	// One divide step: shift in the next dividend bit and try to subtract.
	assign trial      = {rem_q, low_q[31]};
	assign trial_ge   = trial >= {1'b0, w_q};
	assign trial_diff = trial - {1'b0, w_q};

	// Final result: signed term or saturated mean.
	always_comb begin
		prod_sh  = acc_q[63:16];
		qmag     = ovf_q ? 33'h1_0000_0000 : {1'b0, quo_q};
		if (neg_q) begin
			qlim     = (qmag > 33'h0_8000_0000) ? 33'h0_8000_0000 : qmag;
			mean_res = 32'(-qlim);
		end else begin
			qlim     = (qmag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : qmag;
			mean_res = qlim[31:0];
		end
		if (op_q == wir_pkg::OP_MUL) begin
			fin_res = neg_q ? -$signed({16'b0, prod_sh}) : $signed({16'b0, prod_sh});
		end else begin
			fin_res = 64'($signed(mean_res));
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			done_q   <= 1'b0;
			op_q     <= wir_pkg::OP_MUL;
			neg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			mag_q    <= '0;
			acc_q    <= '0;
			mplr_q   <= '0;
			w_q      <= '0;
			rem_q    <= '0;
			low_q    <= '0;
			quo_q    <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						if (req.op == wir_pkg::OP_MUL) begin
							neg_q   <= req.a[31];
							mag_q   <= {32'b0, req.a[31] ? 32'(-req.a[31:0]) : req.a[31:0]};
							acc_q   <= '0;
							mplr_q  <= req.w[31:0];
							state_q <= A_MUL;
						end else begin
							neg_q   <= req.a[63];
							mag_q   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
							w_q     <= req.w;
							state_q <= A_DCHK;
						end
					end
				end
				A_MUL: begin
					if (mplr_q[0]) begin
						acc_q <= acc_q + mag_q;
					end
					mag_q  <= {mag_q[62:0], 1'b0};
					mplr_q <= {1'b0, mplr_q[31:1]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CW'(wir_pkg::ITERS - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_DCHK: begin
					// A quotient of 2^32 or more saturates in any case.
					ovf_q <= mag_q >= {w_q, 16'b0};
					rem_q <= mag_q[63:16];
					low_q <= {mag_q[15:0], 16'b0};
					quo_q <= '0;
					if (mag_q >= {w_q, 16'b0}) begin
						state_q <= A_FIN;
					end else begin
						state_q <= A_DIV;
					end
				end
				A_DIV: begin
					rem_q <= trial_ge ? trial_diff[47:0] : trial[47:0];
					quo_q <= {quo_q[30:0], trial_ge};
					low_q <= {low_q[30:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(wir_pkg::ITERS - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					result_q <= fin_res;
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

[rtl/wir_core.sv]
// Fit core: item stores, pool stack, fitted table and the pool-adjacent-
// violators sequencer that drives the shared arithmetic unit. Depends on
// wir_pkg and wir_arith.
module wir_core (
	input  logic               clk,
	input  logic               arst_n,
	input  wir_pkg::core_cmd_t cmd,
	output wir_pkg::core_rsp_t rsp
);

	localparam int IDX_W = wir_pkg::IDX_W;
	localparam int CNT_W = wir_pkg::CNT_W;

	typedef enum logic [3:0] {
		F_IDLE,
		F_TOP,
		F_LDI,
		F_MULI,
		F_FWD,
		F_FWD_CMP,
		F_FWD_MUL,
		F_BWD,
		F_BWD_CMP,
		F_DIV,
		F_DIVW,
		F_PUSH,
		X_RD,
		X_WR
	} f_state_t;

	// Memories.
	logic signed [31:0]  value_mem  [wir_pkg::MAX_ITEMS];
	logic [31:0]         weight_mem [wir_pkg::MAX_ITEMS];
	wir_pkg::pool_ent_t  pool_mem   [wir_pkg::MAX_ITEMS];
	logic signed [31:0]  fit_mem    [wir_pkg::MAX_ITEMS];

	f_state_t            state_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    b_q;
	logic [IDX_W-1:0]    k_q;
	logic [IDX_W-1:0]    j_q;
	logic signed [31:0]  xb_q;
	logic [47:0]         wb_q;
	logic signed [63:0]  sb_q;
	logic                ph_fwd_q;
	logic                zero_w_q;
	logic                fit_done_q;

	logic signed [31:0]  st_val_q;
	logic [31:0]         st_wt_q;
	wir_pkg::pool_ent_t  pool_rd_q;
	logic signed [31:0]  fit_rd_q;

	logic [CNT_W-1:0]    i_nx;
	logic [CNT_W-1:0]    b_dec;
	logic [CNT_W-1:0]    k_nx;
	logic                st_rd_en;
	logic [IDX_W-1:0]    st_addr;
	logic                pool_rd_en;
	logic [IDX_W-1:0]    pool_raddr;
	logic                pool_we;
	wir_pkg::pool_ent_t  pool_wdata;
	logic                fit_we;
	logic                viol;

	wir_pkg::arith_req_t areq;
	wir_pkg::arith_rsp_t arsp;

	wir_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	assign i_nx  = i_q + 1'b1;
	assign b_dec = b_q - 1'b1;
	assign k_nx  = CNT_W'(k_q) + 1'b1;
	assign viol  = (b_q != '0) && (pool_rd_q.mean > xb_q);

	// Memory port control decoded from the sequencer state.
	always_comb begin
		st_rd_en   = ((state_q == F_TOP) && (i_q < n_q)) ||
		             ((state_q == F_FWD) && (i_nx < n_q));
		st_addr    = (state_q == F_FWD) ? i_nx[IDX_W-1:0] : i_q[IDX_W-1:0];
		pool_rd_en = (((state_q == F_LDI) || (state_q == F_BWD)) && (b_q != '0)) ||
		             (state_q == X_RD);
		pool_raddr = (state_q == X_RD) ? k_q : b_dec[IDX_W-1:0];
		pool_we    = state_q == F_PUSH;
		pool_wdata.mean     = xb_q;
		pool_wdata.wsum     = wb_q;
		pool_wdata.sum      = sb_q;
		pool_wdata.last_idx = i_q[IDX_W-1:0];
		fit_we     = state_q == X_WR;
	end

	// Requests to the arithmetic unit.
	always_comb begin
		areq.start = 1'b0;
		areq.op    = wir_pkg::OP_MUL;
		areq.a     = 64'(st_val_q);
		areq.w     = {16'b0, st_wt_q};
		if (state_q == F_LDI) begin
			areq.start = 1'b1;
		end else if ((state_q == F_FWD_CMP) && (xb_q >= st_val_q)) begin
			areq.start = 1'b1;
		end else if ((state_q == F_DIV) && (wb_q != '0)) begin
			areq.start = 1'b1;
			areq.op    = wir_pkg::OP_DIV;
			areq.a     = sb_q;
			areq.w     = wb_q;
		end
	end

	// Item stores.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_mem[cmd.load_addr]  <= cmd.value;
			weight_mem[cmd.load_addr] <= cmd.weight;
		end
		if (st_rd_en) begin
			st_val_q <= value_mem[st_addr];
			st_wt_q  <= weight_mem[st_addr];
		end
	end

	// Pool stack.
	always_ff @(posedge clk) begin
		if (pool_we) begin
			pool_mem[b_q[IDX_W-1:0]] <= pool_wdata;
		end
		if (pool_rd_en) begin
			pool_rd_q <= pool_mem[pool_raddr];
		end
	end

	// Fitted table, one entry per item of the last fit.
	always_ff @(posedge clk) begin
		if (fit_we) begin
			fit_mem[j_q] <= pool_rd_q.mean;
		end
		if (cmd.rd) begin
			fit_rd_q <= fit_mem[cmd.rd_idx];
		end
	end

	// Pool-adjacent-violators sequencer, then expansion of pool means.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			n_q        <= '0;
			i_q        <= '0;
			b_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
			xb_q       <= '0;
			wb_q       <= '0;
			sb_q       <= '0;
			ph_fwd_q   <= 1'b0;
			zero_w_q   <= 1'b0;
			fit_done_q <= 1'b0;
		end else begin
			zero_w_q   <= 1'b0;
			fit_done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (cmd.fit_start) begin
						n_q     <= cmd.fit_n;
						i_q     <= '0;
						b_q     <= '0;
						state_q <= F_TOP;
					end
				end
				F_TOP: begin
					if (i_q < n_q) begin
						state_q <= F_LDI;
					end else begin
						k_q     <= '0;
						j_q     <= '0;
						state_q <= X_RD;
					end
				end
				F_LDI: begin
					xb_q    <= st_val_q;
					wb_q    <= {16'b0, st_wt_q};
					state_q <= F_MULI;
				end
				F_MULI: begin
					if (arsp.done) begin
						if (viol) begin
							b_q      <= b_dec;
							sb_q     <= arsp.result + pool_rd_q.sum;
							wb_q     <= wb_q + pool_rd_q.wsum;
							ph_fwd_q <= 1'b1;
							state_q  <= F_DIV;
						end else begin
							sb_q    <= arsp.result;
							state_q <= F_PUSH;
						end
					end
				end
				F_FWD: begin
					state_q <= (i_nx < n_q) ? F_FWD_CMP : F_BWD;
				end
				F_FWD_CMP: begin
					if (xb_q >= st_val_q) begin
						i_q     <= i_nx;
						state_q <= F_FWD_MUL;
					end else begin
						state_q <= F_BWD;
					end
				end
				F_FWD_MUL: begin
					if (arsp.done) begin
						sb_q     <= sb_q + arsp.result;
						wb_q     <= wb_q + {16'b0, st_wt_q};
						ph_fwd_q <= 1'b1;
						state_q  <= F_DIV;
					end
				end
				F_BWD: begin
					state_q <= (b_q != '0) ? F_BWD_CMP : F_PUSH;
				end
				F_BWD_CMP: begin
					if (pool_rd_q.mean > xb_q) begin
						b_q      <= b_dec;
						sb_q     <= sb_q + pool_rd_q.sum;
						wb_q     <= wb_q + pool_rd_q.wsum;
						ph_fwd_q <= 1'b0;
						state_q  <= F_DIV;
					end else begin
						state_q <= F_PUSH;
					end
				end
				F_DIV: begin
					// A pool of zero total weight takes mean zero.
					if (wb_q == '0) begin
						xb_q     <= '0;
						zero_w_q <= 1'b1;
						state_q  <= ph_fwd_q ? F_FWD : F_BWD;
					end else begin
						state_q <= F_DIVW;
					end
				end
				F_DIVW: begin
					if (arsp.done) begin
						xb_q    <= arsp.result[31:0];
						state_q <= ph_fwd_q ? F_FWD : F_BWD;
					end
				end
				F_PUSH: begin
					b_q     <= b_q + 1'b1;
					i_q     <= i_nx;
					state_q <= F_TOP;
				end
				X_RD: begin
					state_q <= X_WR;
				end
				X_WR: begin
					j_q <= j_q + 1'b1;
					if (j_q == pool_rd_q.last_idx) begin
						if (k_nx == b_q) begin
							fit_done_q <= 1'b1;
							state_q    <= F_IDLE;
						end else begin
							k_q     <= k_nx[IDX_W-1:0];
							state_q <= X_RD;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.zero_w   = zero_w_q;
	assign rsp.fit_done = fit_done_q;
	assign rsp.rd_data  = fit_rd_q;

endmodule

[rtl/weighted_isotonic_regression.sv]
// Weighted isotonic regression by pool-adjacent-violators. A load item stores
// one value and weight unless the stores are full; a load marked last starts
// the fit, during which the block stalls new items. Every item of the fit
// passes once through the shared serial multiplier and every pool merge of
// nonzero total weight through the same unit as a serial divider; the fitted
// table is then written at one entry per cycle, with one pool read before
// the entries of each pool. A read item returns the fitted value at its index.
// Top level: handshakes, item count, fit status and output register.
// Depends on wir_pkg and wir_core.
module weighted_isotonic_regression (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic               command,
	input  logic signed [31:0] value,
	input  logic [31:0]        weight,
	input  logic [9:0]         index,
	input  logic               last,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] fitted,
	output logic [9:0]         position,
	output logic [1:0]         status
);

	localparam int IDX_W = wir_pkg::IDX_W;
	localparam int CNT_W = wir_pkg::CNT_W;

	typedef enum logic [1:0] {
		T_IDLE,
		T_FIT,
		T_READ
	} t_state_t;

	t_state_t            state_q;
	logic [CNT_W-1:0]    item_count_q;
	logic [CNT_W-1:0]    fit_n_q;
	logic [CNT_W-1:0]    fit_len_q;
	logic [1:0]          fit_status_q;
	logic [9:0]          pos_q;
	logic                res_valid_q;
	logic signed [31:0]  fitted_q;
	logic [9:0]          position_q;
	logic [1:0]          status_q;

	logic                accept;
	logic                is_load;
	logic                full;
	wir_pkg::core_cmd_t  ccmd;
	wir_pkg::core_rsp_t  crsp;

	assign cmd_stall = state_q != T_IDLE;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_load   = command == wir_pkg::CMD_LOAD;
	assign full      = item_count_q == CNT_W'(wir_pkg::MAX_ITEMS);

	// Commands to the fit core.
	always_comb begin
		ccmd.load      = accept && is_load && !full;
		ccmd.load_addr = item_count_q[IDX_W-1:0];
		ccmd.value     = value;
		ccmd.weight    = weight;
		ccmd.fit_start = accept && is_load && last;
		ccmd.fit_n     = full ? item_count_q : item_count_q + 1'b1;
		ccmd.rd        = accept && !is_load;
		ccmd.rd_idx    = index[IDX_W-1:0];
	end

	wir_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ccmd),
		.rsp    (crsp)
	);

	// Control state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			item_count_q <= '0;
			fit_n_q      <= '0;
			fit_len_q    <= '0;
			fit_status_q <= wir_pkg::ST_OK;
			pos_q        <= '0;
			res_valid_q  <= 1'b0;
			fitted_q     <= '0;
			position_q   <= '0;
			status_q     <= wir_pkg::ST_OK;
		end else begin
			// The read state sets the output valid itself.
			if (res_valid_q && !res_stall && (state_q != T_READ)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept && is_load) begin
						if (full) begin
							fit_status_q <= wir_pkg::ST_OVERFLOW;
						end else if (item_count_q == '0) begin
							fit_status_q <= wir_pkg::ST_OK;
						end
						if (last) begin
							item_count_q <= '0;
							fit_n_q      <= ccmd.fit_n;
							state_q      <= T_FIT;
						end else begin
							item_count_q <= ccmd.fit_n;
						end
					end else if (accept) begin
						pos_q   <= index;
						state_q <= T_READ;
					end
				end
				T_FIT: begin
					if (crsp.zero_w && (fit_status_q != wir_pkg::ST_OVERFLOW)) begin
						fit_status_q <= wir_pkg::ST_ZERO_W;
					end
					if (crsp.fit_done) begin
						fit_len_q <= fit_n_q;
						state_q   <= T_IDLE;
					end
				end
				T_READ: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						fitted_q    <= (CNT_W'(pos_q) < fit_len_q) ? crsp.rd_data : '0;
						position_q  <= pos_q;
						status_q    <= fit_status_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign fitted    = fitted_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule

[rtl/wir_checker.sv]
// Port-level checks for the weighted isotonic regression block, bound to
// its top level. Depends on the top level's ports only.
module wir_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               command,
	input logic               last,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [31:0] fitted,
	input logic [9:0]         position,
	input logic [1:0]         status
);

	logic acc;

	assign acc = cmd_valid && !cmd_stall;

	// A read item keeps the block busy while its result is formed.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && command |=> cmd_stall)
		else $error("block took an item right after a read");

	// The final load starts a fit, which blocks new items.
	a_fit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !command && last |=> cmd_stall)
		else $error("block took an item right after the final load");

	// An ordinary load does not stall the block.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !command && !last |=> !cmd_stall)
		else $error("ordinary load stalled the block");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(fitted) &&
		$stable(position) && $stable(status))
		else $error("stalled result changed");

endmodule

bind weighted_isotonic_regression wir_checker u_wir_checker (.*);
